// ----- hw/rtl/tfdq_pkg.sv -----
// Package for the transmit frame descriptor queue.
// Holds the command and status codes, the descriptor type and the default ring depth.
// No dependencies.
`timescale 1ns / 1ps

package tfdq_pkg;

	localparam int SLOTS_DEFAULT = 8;

	// commands
	localparam logic [1:0] CMD_ENQUEUE  = 2'd0;
	localparam logic [1:0] CMD_TRY_TX   = 2'd1;
	localparam logic [1:0] CMD_TX_DONE  = 2'd2;

	// result status codes
	localparam logic [2:0] ST_ENQUEUED   = 3'd0;
	localparam logic [2:0] ST_FULL_DROP  = 3'd1;
	localparam logic [2:0] ST_LAUNCHED   = 3'd2;
	localparam logic [2:0] ST_NOTHING    = 3'd3;
	localparam logic [2:0] ST_REFUSED    = 3'd4;
	localparam logic [2:0] ST_RETIRED    = 3'd5;
	localparam logic [2:0] ST_SPURIOUS   = 3'd6;
	localparam logic [2:0] ST_TAIL_EMPTY = 3'd7;

	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] len;
	} desc_t;

endpackage

// ----- hw/rtl/tx_frame_descriptor_queue.sv -----
// Transmit frame descriptor queue, top level.
// Depends on tfdq_pkg; the port checker in tfdq_checker.sv binds to this module.
//
// A ring of SLOTS frame descriptors (buffer address and length). Each input
// transaction carries one command: enqueue a descriptor at the head, offer the
// tail descriptor to the output port, or report that the port finished sending
// the tail frame. Every command gives exactly one result transaction with a
// status code, the head slot index, the offered or retired descriptor, the
// queue and peak lengths and six 32-bit wrapping statistics counters. A command
// passes an input register and a result register on its way to the outputs,
// and one command is taken every cycle while the result side keeps up. The
// descriptor memory is read with a registered port at the tail pointer of the
// following command, with a bypass when the same slot is written.
// No clearing pass after reset.
`timescale 1ns / 1ps

module tx_frame_descriptor_queue #(
	parameter int SLOTS = tfdq_pkg::SLOTS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] buffer_address,
	input  logic [15:0] frame_length,
	input  logic        port_accepts,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [2:0]  slot_index,
	output logic [31:0] tx_address,
	output logic [15:0] tx_length,
	output logic [3:0]  queue_length,
	output logic [3:0]  peak_length,
	output logic [31:0] packets_in,
	output logic [31:0] packets_out,
	output logic [31:0] bytes_in,
	output logic [31:0] bytes_out,
	output logic [31:0] full_drops,
	output logic [31:0] error_count
);

	import tfdq_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
	localparam logic [LW-1:0] FULL_LEN = LW'(SLOTS);

	// input stage
	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [31:0] addr_s1;
	logic [15:0] len_s1;
	logic        acc_s1;

	// ring state
	logic [IW-1:0] head_q, tail_q;
	logic          blocked_q;
	logic [LW-1:0] len_now_q, peak_q;
	logic [31:0]   pk_in_q, pk_out_q, by_in_q, by_out_q, drop_q, err_q;

	// descriptor memory and its registered tail read
	desc_t mem_q [SLOTS];
	desc_t rd_q, byp_data_q, tail_desc;
	logic  byp_q;

	// next-state values
	logic [IW-1:0] head_n, tail_n, rd_idx;
	logic          blocked_n;
	logic [LW-1:0] len_n, peak_n;
	logic [31:0]   pk_in_n, pk_out_n, by_in_n, by_out_n, drop_n, err_n;
	logic [2:0]    status_n;
	desc_t         tx_n;
	logic          wr_en;
	logic          fire, take;

	// handshake: a command in s1 completes when the result register is free
	assign fire     = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !fire;
	assign take     = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1  <= cmd;
			addr_s1 <= buffer_address;
			len_s1  <= frame_length;
			acc_s1  <= port_accepts;
		end
	end

	assign tail_desc = byp_q ? byp_data_q : rd_q;

	// command decode and state update
	always_comb begin
		head_n    = head_q;
		tail_n    = tail_q;
		blocked_n = blocked_q;
		len_n     = len_now_q;
		peak_n    = peak_q;
		pk_in_n   = pk_in_q;
		pk_out_n  = pk_out_q;
		by_in_n   = by_in_q;
		by_out_n  = by_out_q;
		drop_n    = drop_q;
		err_n     = err_q;
		status_n  = ST_NOTHING;
		tx_n      = '0;
		wr_en     = 1'b0;
		unique case (cmd_s1)
			CMD_ENQUEUE: begin
				if (len_now_q < FULL_LEN) begin
					wr_en    = 1'b1;
					len_n    = len_now_q + 1'b1;
					pk_in_n  = pk_in_q + 32'd1;
					by_in_n  = by_in_q + 32'(len_s1);
					if (len_n > peak_q) begin
						peak_n = len_n;
					end
					head_n   = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
					status_n = ST_ENQUEUED;
				end else begin
					drop_n   = drop_q + 32'd1;
					status_n = ST_FULL_DROP;
				end
			end
			CMD_TRY_TX: begin
				// the tail slot is ready exactly when queued and not blocked
				if (!blocked_q && len_now_q != '0) begin
					tx_n = tail_desc;
					if (acc_s1) begin
						blocked_n = 1'b1;
						status_n  = ST_LAUNCHED;
					end else begin
						status_n  = ST_REFUSED;
					end
				end
			end
			CMD_TX_DONE: begin
				// the tail slot is in transmission exactly when blocked
				blocked_n = 1'b0;
				if (!blocked_q) begin
					err_n    = err_q + 32'd1;
					status_n = ST_SPURIOUS;
				end else if (len_now_q != '0) begin
					tx_n     = tail_desc;
					pk_out_n = pk_out_q + 32'd1;
					by_out_n = by_out_q + 32'(tail_desc.len);
					len_n    = len_now_q - 1'b1;
					tail_n   = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
					status_n = ST_RETIRED;
				end else begin
					err_n    = err_q + 32'd1;
					status_n = ST_TAIL_EMPTY;
				end
			end
			default: begin
				status_n = ST_NOTHING;
			end
		endcase
	end

	// ring state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			blocked_q <= 1'b0;
			len_now_q <= '0;
			peak_q    <= '0;
			pk_in_q   <= '0;
			pk_out_q  <= '0;
			by_in_q   <= '0;
			by_out_q  <= '0;
			drop_q    <= '0;
			err_q     <= '0;
		end else if (fire) begin
			head_q    <= head_n;
			tail_q    <= tail_n;
			blocked_q <= blocked_n;
			len_now_q <= len_n;
			peak_q    <= peak_n;
			pk_in_q   <= pk_in_n;
			pk_out_q  <= pk_out_n;
			by_in_q   <= by_in_n;
			by_out_q  <= by_out_n;
			drop_q    <= drop_n;
			err_q     <= err_n;
		end
	end

	// descriptor memory: write at head, read ahead at the next tail
	assign rd_idx = fire ? tail_n : tail_q;

	always_ff @(posedge clk) begin
		if (fire && wr_en) begin
			mem_q[head_q] <= '{addr: addr_s1, len: len_s1};
		end
	end

	always_ff @(posedge clk) begin
		rd_q       <= mem_q[rd_idx];
		byp_data_q <= '{addr: addr_s1, len: len_s1};
	end

	// same-slot write and read: take the new descriptor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= fire && wr_en && (head_q == rd_idx);
		end
	end

	// result register
	logic [IW+2:0] head_ext;
	logic [LW+3:0] len_ext, peak_ext;

	assign head_ext = {3'b000, head_n};
	assign len_ext  = {4'b0000, len_n};
	assign peak_ext = {4'b0000, peak_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status       <= status_n;
			slot_index   <= head_ext[2:0];
			tx_address   <= tx_n.addr;
			tx_length    <= tx_n.len;
			queue_length <= len_ext[3:0];
			peak_length  <= peak_ext[3:0];
			packets_in   <= pk_in_n;
			packets_out  <= pk_out_n;
			bytes_in     <= by_in_n;
			bytes_out    <= by_out_n;
			full_drops   <= drop_n;
			error_count  <= err_n;
		end
	end

endmodule

// ----- hw/rtl/tfdq_checker.sv -----
// Port checker for the transmit frame descriptor queue, bound to the top level.
// Depends on tfdq_pkg for the status codes.
`timescale 1ns / 1ps

module tfdq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [31:0] tx_address,
	input logic [15:0] tx_length,
	input logic [3:0]  queue_length,
	input logic [3:0]  peak_length
);

	import tfdq_pkg::*;

	// the input only stalls behind a stalled result transaction
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while the result side is free");

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(tx_address))
		else $error("stalled result changed");

	// peak never below the current length
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> peak_length >= queue_length)
		else $error("peak length below queue length");

	// descriptor fields only on launched, refused or retired results
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_LAUNCHED && status != ST_REFUSED && status != ST_RETIRED
		|-> tx_address == 32'd0 && tx_length == 16'd0)
		else $error("descriptor shown on a result that has none");

	// a drop only happens with a non-empty ring, an enqueue leaves it non-empty
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL_DROP || status == ST_ENQUEUED)
		|-> queue_length != 4'd0 && peak_length != 4'd0)
		else $error("empty queue after enqueue or drop");

endmodule

bind tx_frame_descriptor_queue tfdq_checker u_tfdq_checker (.*);
